@@ src/cpp_pkg.sv @@
// Shared types and constants for the control pad packet parser.
// No dependencies; used by cpp_parser and control_pad_packet_parser.
package cpp_pkg;

  localparam logic [7:0] CharStart = 8'h21;
  localparam logic [7:0] CharB     = 8'h42;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CharQ     = 8'h51;
  localparam logic [7:0] CharJ     = 8'h4a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharEight = 8'h38;

  localparam logic [2:0] KindButtons = 3'd0;
  localparam logic [2:0] KindAccel   = 3'd1;
  localparam logic [2:0] KindGyro    = 3'd2;
  localparam logic [2:0] KindQuat    = 3'd3;
  localparam logic [2:0] KindJoy     = 3'd4;
  localparam logic [2:0] KindNone    = 3'd7;

  localparam logic [4:0] PosHunt    = 5'd0;
  localparam logic [4:0] PosType    = 5'd1;
  localparam logic [4:0] PosPayload = 5'd2;

  localparam int unsigned StoreDepth = 16;

  typedef struct packed {
    logic [7:0]       echo_byte;
    logic             packet_done;
    logic             checksum_bad;
    logic [2:0]       packet_type;
    logic [7:0]       button_bits;
    logic [3:0][31:0] words;
  } result_t;

  function automatic logic [4:0] final_pos(input logic [2:0] kind);
    logic [4:0] fin;
    unique case (kind)
      KindButtons:       fin = 5'd4;
      KindAccel, KindGyro: fin = 5'd14;
      KindQuat, KindJoy: fin = 5'd18;
      default:           fin = 5'd0;
    endcase
    return fin;
  endfunction

endpackage

@@ src/control_pad_packet_parser.sv @@
// Control pad packet parser top level: input register, parser stage, result register.
// Depends on cpp_pkg and cpp_parser.
//
// One byte is taken per item and one result item comes out for each, at one item per
// clock cycle sustained while the output does not stall. An item passes the input
// register and then the result register. The rate is set by the parser stage, which
// updates the framing state, checksum, payload store and button map of one byte in a
// single cycle. A stalled result holds the input register; in_stall_o rises only
// while both registers are full and the output side stalls.
module control_pad_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  echo_byte_o,
  output logic        packet_done_o,
  output logic        checksum_bad_o,
  output logic [2:0]  packet_type_o,
  output logic [7:0]  button_bits_o,
  output logic [31:0] word_zero_o,
  output logic [31:0] word_one_o,
  output logic [31:0] word_two_o,
  output logic [31:0] word_three_o
);
  import cpp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;
  logic       step;

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  cpp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (!out_valid_q || !out_stall_i) out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_byte_q <= rx_byte_i;
    if (step) res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign echo_byte_o    = res_q.echo_byte;
  assign packet_done_o  = res_q.packet_done;
  assign checksum_bad_o = res_q.checksum_bad;
  assign packet_type_o  = res_q.packet_type;
  assign button_bits_o  = res_q.button_bits;
  assign word_zero_o    = res_q.words[0];
  assign word_one_o     = res_q.words[1];
  assign word_two_o     = res_q.words[2];
  assign word_three_o   = res_q.words[3];

  a_done_bad_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(packet_done_o && checksum_bad_o))
    else $error("done and bad flagged together");

  a_type_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !packet_done_o) |-> (packet_type_o == KindButtons
      && word_zero_o == '0 && word_three_o == '0))
    else $error("type or words set without a completed packet");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side free");

  a_map_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !packet_done_o) |=>
      (!out_valid_o || button_bits_o == $past(button_bits_o) || packet_done_o))
    else $error("button map changed without a completed packet");

endmodule

@@ src/cpp_parser.sv @@
// Parser stage: framing state, running checksum, payload store and button map.
// Depends on cpp_pkg; consumes one registered byte per step.
module cpp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output cpp_pkg::result_t  result_o
);
  import cpp_pkg::*;

  logic [4:0] pos_q, pos_d;
  logic [2:0] kind_q, kind_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] map_q, map_d;
  logic [StoreDepth-1:0][7:0] store_q, store_d;

  logic [4:0] fin;
  logic [2:0] kind_dec;
  logic [7:0] mask;
  logic       digit_ok;

  assign fin      = final_pos(kind_q);
  assign digit_ok = (store_q[0] >= CharOne) && (store_q[0] <= CharEight);
  assign mask     = 8'd1 << store_q[0][2:0] - 3'd1;

  always_comb begin
    unique case (byte_i)
      CharB:   kind_dec = KindButtons;
      CharA:   kind_dec = KindAccel;
      CharG:   kind_dec = KindGyro;
      CharQ:   kind_dec = KindQuat;
      CharJ:   kind_dec = KindJoy;
      default: kind_dec = KindNone;
    endcase
  end

  always_comb begin
    pos_d   = pos_q;
    kind_d  = kind_q;
    sum_d   = sum_q;
    map_d   = map_q;
    store_d = store_q;
    result_o = '0;
    result_o.echo_byte = byte_i;

    priority if (pos_q == PosHunt) begin
      if (byte_i == CharStart) begin
        pos_d = PosType;
        sum_d = sum_q + byte_i;
      end
    end else if (pos_q == PosType) begin
      if (kind_dec == KindNone) begin
        pos_d  = PosHunt;
        sum_d  = '0;
        kind_d = KindNone;
      end else begin
        kind_d  = kind_dec;
        store_d = '0;
        pos_d   = PosPayload;
        sum_d   = sum_q + byte_i;
      end
    end else if (fin == 5'd0 || pos_q > fin) begin
      pos_d  = PosHunt;
      sum_d  = '0;
      kind_d = KindNone;
    end else if (pos_q == fin) begin
      if (~sum_q != byte_i) begin
        result_o.checksum_bad = 1'b1;
      end else begin
        result_o.packet_done = 1'b1;
        result_o.packet_type = kind_q;
        if (kind_q == KindButtons) begin
          if (digit_ok) begin
            if (store_q[1] != CharZero) map_d = map_q | mask;
            else                        map_d = map_q & ~mask;
          end
        end else begin
          for (int w = 0; w < 4; w++) begin
            result_o.words[w] = {store_q[4*w+3], store_q[4*w+2],
                                 store_q[4*w+1], store_q[4*w]};
          end
        end
      end
      pos_d  = PosHunt;
      sum_d  = '0;
      kind_d = KindNone;
    end else begin
      store_d[pos_q[3:0] - 4'd2] = byte_i;
      pos_d = pos_q + 5'd1;
      sum_d = sum_q + byte_i;
    end

    result_o.button_bits = map_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      kind_q  <= KindNone;
      sum_q   <= '0;
      map_q   <= '0;
      store_q <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      kind_q  <= kind_d;
      sum_q   <= sum_d;
      map_q   <= map_d;
      store_q <= store_d;
    end
  end

endmodule
